FILE: rtl/joystick_center_calibrate_and_classify_assert.svh
// Assertion macros for the joystick calibrate-and-classify block.
// Included by the top level; no other dependencies.
`ifndef JOYSTICK_CENTER_CALIBRATE_AND_CLASSIFY_ASSERT_SVH
`define JOYSTICK_CENTER_CALIBRATE_AND_CLASSIFY_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define JCCC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define JCCC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/jccc_pkg.sv
// Shared types and constants for the joystick calibrate-and-classify block.
// No dependencies.
`timescale 1ns / 1ps

package jccc_pkg;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIFF,
      ST_NUM,
      ST_DIV,
      ST_CLASS,
      ST_OUT
   } state_type;

   // Per-lane control from the sequencer
   typedef struct packed {
      logic load_diff;
      logic load_num;
      logic step;
   } lane_ctrl_type;

   localparam int NUM_LANES   = 4;
   localparam int PCT_BITS    = 8;
   localparam int QUO_BITS    = 9;           // one overflow bit plus 8 quotient bits
   localparam int DIV_STEPS   = QUO_BITS;
   localparam int STEP_BITS   = $clog2(DIV_STEPS);
   localparam int SCALE       = 100;
   localparam int SCALE_BITS  = 7;
   localparam int MARGIN_BITS = 7;
   localparam int DIR_BITS    = 3;

   localparam logic [MARGIN_BITS-1:0] MARGIN_RESET = 7'd10;

   // Reference centers per sample, scaled by the sample count at reset (x1, y1, x2, y2)
   localparam int CENTER_REF [NUM_LANES] = '{128, 128, 130, 133};

   localparam logic [QUO_BITS-1:0] POS_LIMIT = 9'd127;
   localparam logic [QUO_BITS-1:0] NEG_LIMIT = 9'd128;
   localparam logic signed [PCT_BITS-1:0] PCT_MAX = 8'sd127;
   localparam logic signed [PCT_BITS-1:0] PCT_MIN = -8'sd128;

   localparam logic [DIR_BITS-1:0] DIR_NEUTRAL = 3'd0;
   localparam logic [DIR_BITS-1:0] DIR_RIGHT   = 3'd1;
   localparam logic [DIR_BITS-1:0] DIR_LEFT    = 3'd2;
   localparam logic [DIR_BITS-1:0] DIR_UP      = 3'd3;
   localparam logic [DIR_BITS-1:0] DIR_DOWN    = 3'd4;

endpackage

FILE: rtl/jccc_calib.sv
// Calibration accumulators, sample counter and stored center sums.
// Depends on jccc_pkg.
`timescale 1ns / 1ps

module jccc_calib #(
   parameter int CAL_SAMPLES = 10,
   parameter int SAMPLE_BITS = 8,
   parameter int SUM_BITS    = 12,
   parameter int CNT_BITS    = 4
) (
   input  logic clock,
   input  logic reset,
   input  logic cal_en,
   input  logic [jccc_pkg::NUM_LANES-1:0][SAMPLE_BITS-1:0] samples,
   output logic [jccc_pkg::NUM_LANES-1:0][SUM_BITS-1:0]    centers,
   output logic last
);
   import jccc_pkg::*;

   logic [NUM_LANES-1:0][SUM_BITS-1:0] acc_ff, acc_in;
   logic [NUM_LANES-1:0][SUM_BITS-1:0] center_ff, center_in;
   logic [CNT_BITS-1:0]                cnt_ff, cnt_in;

   // This transaction completes the calibration set
   assign last    = (cnt_ff == CNT_BITS'(CAL_SAMPLES - 1));
   assign centers = center_ff;

   // Accumulate, and on the last sample move sums to centers
   always_comb begin
      acc_in    = acc_ff;
      center_in = center_ff;
      cnt_in    = cnt_ff;
      if (cal_en) begin
         for (int i = 0; i < NUM_LANES; i++) begin
            acc_in[i] = acc_ff[i] + SUM_BITS'(samples[i]);
         end
         cnt_in = cnt_ff + CNT_BITS'(1);
         if (last) begin
            center_in = acc_in;
            acc_in    = '0;
            cnt_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         cnt_ff <= '0;
         for (int i = 0; i < NUM_LANES; i++) begin
            center_ff[i] <= SUM_BITS'(CAL_SAMPLES * CENTER_REF[i]);
         end
      end else begin
         acc_ff    <= acc_in;
         cnt_ff    <= cnt_in;
         center_ff <= center_in;
      end
   end

endmodule

FILE: rtl/jccc_lane.sv
// One axis lane: offset from center, scale by 100, bit-serial restoring
// division by the center sum, then saturation to 8 bits. Depends on jccc_pkg.
`timescale 1ns / 1ps

module jccc_lane #(
   parameter int CAL_SAMPLES = 10,
   parameter int SAMPLE_BITS = 8,
   parameter int SUM_BITS    = 12
) (
   input  logic clock,
   input  jccc_pkg::lane_ctrl_type ctrl,
   input  logic [SAMPLE_BITS-1:0] sample,
   input  logic [SUM_BITS-1:0]    center,
   output logic signed [jccc_pkg::PCT_BITS-1:0] pct
);
   import jccc_pkg::*;

   localparam int NUM_BITS = SUM_BITS + SCALE_BITS;
   localparam int DIV_BITS = SUM_BITS + QUO_BITS - 1;

   logic                neg_ff, neg_in;
   logic                nz_ff, nz_in;
   logic [SUM_BITS-1:0] mag_ff, mag_in;
   logic [NUM_BITS-1:0] rem_ff, rem_in;
   logic [DIV_BITS-1:0] div_ff, div_in;
   logic [QUO_BITS-1:0] quo_ff, quo_in;

   logic [SUM_BITS-1:0] prod;
   logic                ge;

   assign prod = SUM_BITS'(CAL_SAMPLES) * SUM_BITS'(sample);
   assign ge   = (DIV_BITS'(rem_ff) >= div_ff);

   // Load offset, then scaled numerator, then shift out one quotient bit a cycle
   always_comb begin
      neg_in = neg_ff;
      nz_in  = nz_ff;
      mag_in = mag_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      quo_in = quo_ff;
      if (ctrl.load_diff) begin
         neg_in = (prod < center);
         mag_in = (prod < center) ? (center - prod) : (prod - center);
         div_in = {center, (QUO_BITS - 1)'(0)};
      end
      if (ctrl.load_num) begin
         rem_in = NUM_BITS'(mag_ff) * NUM_BITS'(SCALE);
         nz_in  = (mag_ff != '0);
         quo_in = '0;
      end
      if (ctrl.step) begin
         if (ge) begin
            rem_in = rem_ff - NUM_BITS'(div_ff);
         end
         quo_in = {quo_ff[QUO_BITS-2:0], ge};
         div_in = div_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      nz_ff  <= nz_in;
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
   end

   // Apply sign and saturate; a zero numerator is zero even for a zero center
   always_comb begin
      if (!nz_ff) begin
         pct = '0;
      end else if (!neg_ff) begin
         pct = (quo_ff > POS_LIMIT) ? PCT_MAX : signed'(quo_ff[PCT_BITS-1:0]);
      end else begin
         pct = (quo_ff >= NEG_LIMIT) ? PCT_MIN
                                     : signed'(PCT_BITS'(~quo_ff[PCT_BITS-1:0] + 8'd1));
      end
   end

endmodule

FILE: rtl/joystick_center_calibrate_and_classify.sv
// Measure item: each axis lane loads the offset, then the scaled numerator, then runs
// the 9-step bit-serial divider; then direction is classified and the output loaded.
// Calibration item: straight to output load; no new item is taken before that load.
// A new item is taken while an earlier result waits in the output register.
// Reset (synchronous): margin 10, counter and accumulators zero, centers
// CAL_SAMPLES times 128, 128, 130, 133; no clearing pass.
`timescale 1ns / 1ps
`include "joystick_center_calibrate_and_classify_assert.svh"

module joystick_center_calibrate_and_classify #(
   parameter int CAL_SAMPLES = 10,
   parameter int SAMPLE_BITS = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic req_action,
   input  logic [SAMPLE_BITS-1:0] req_stick1_x,
   input  logic [SAMPLE_BITS-1:0] req_stick1_y,
   input  logic [SAMPLE_BITS-1:0] req_stick2_x,
   input  logic [SAMPLE_BITS-1:0] req_stick2_y,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic signed [jccc_pkg::PCT_BITS-1:0] rsp_stick1_x_percent,
   output logic signed [jccc_pkg::PCT_BITS-1:0] rsp_stick1_y_percent,
   output logic signed [jccc_pkg::PCT_BITS-1:0] rsp_stick2_x_percent,
   output logic signed [jccc_pkg::PCT_BITS-1:0] rsp_stick2_y_percent,
   output logic [jccc_pkg::DIR_BITS-1:0] rsp_direction,
   output logic rsp_calibration_done,
   input  logic csr_write_enable,
   input  logic [jccc_pkg::MARGIN_BITS-1:0] csr_write_data
);
   import jccc_pkg::*;

   localparam int SUM_BITS = $clog2(CAL_SAMPLES * ((1 << SAMPLE_BITS) - 1) + 1);
   localparam int CNT_BITS = $clog2(CAL_SAMPLES + 1);

   state_type state_ff, state_in;
   logic [STEP_BITS-1:0]   step_ff, step_in;
   logic [MARGIN_BITS-1:0] margin_ff, margin_in;
   logic is_cal_ff, is_cal_in;
   logic cal_done_ff, cal_done_in;
   logic [DIR_BITS-1:0] dir_ff, dir_in;

   logic [NUM_LANES-1:0][SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic [NUM_LANES-1:0][SAMPLE_BITS-1:0] req_samples;
   logic [NUM_LANES-1:0][SUM_BITS-1:0]    centers;
   logic signed [PCT_BITS-1:0]            lane_pct [NUM_LANES];

   logic rsp_valid_ff, rsp_valid_in;
   logic signed [PCT_BITS-1:0] pct_ff [NUM_LANES];
   logic [DIR_BITS-1:0] rsp_dir_ff;
   logic rsp_done_ff;

   lane_ctrl_type lane_ctrl;
   logic accept, cal_en, cal_last, out_load;
   logic signed [PCT_BITS:0] cx, cy, ax, ay, m;

   assign accept      = req_valid && req_ready;
   assign cal_en      = accept && req_action;
   assign req_samples = {req_stick2_y, req_stick2_x, req_stick1_y, req_stick1_x};

   jccc_calib #(
      .CAL_SAMPLES (CAL_SAMPLES),
      .SAMPLE_BITS (SAMPLE_BITS),
      .SUM_BITS    (SUM_BITS),
      .CNT_BITS    (CNT_BITS)
   ) u_calib (
      .clock   (clock),
      .reset   (reset),
      .cal_en  (cal_en),
      .samples (req_samples),
      .centers (centers),
      .last    (cal_last)
   );

   for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
      jccc_lane #(
         .CAL_SAMPLES (CAL_SAMPLES),
         .SAMPLE_BITS (SAMPLE_BITS),
         .SUM_BITS    (SUM_BITS)
      ) u_lane (
         .clock  (clock),
         .ctrl   (lane_ctrl),
         .sample (sample_ff[g]),
         .center (centers[g]),
         .pct    (lane_pct[g])
      );
   end

   // Direction of the first stick from the saturated percents
   always_comb begin
      cx = (PCT_BITS + 1)'(lane_pct[0]);
      cy = (PCT_BITS + 1)'(lane_pct[1]);
      ax = (cx < 0) ? -cx : cx;
      ay = (cy < 0) ? -cy : cy;
      m  = signed'((PCT_BITS + 1)'(margin_ff));
      if (cx > m) begin
         dir_in = (cx > ay) ? DIR_RIGHT : ((cy > 0) ? DIR_UP : DIR_DOWN);
      end else if (cx < -m) begin
         dir_in = (ax > ay) ? DIR_LEFT : ((cy > 0) ? DIR_UP : DIR_DOWN);
      end else if (cy > m) begin
         dir_in = DIR_UP;
      end else if (cy < -m) begin
         dir_in = DIR_DOWN;
      end else begin
         dir_in = DIR_NEUTRAL;
      end
      if (state_ff != ST_CLASS) begin
         dir_in = dir_ff;
      end
   end

   // Sequencer: next state, lane control, handshake
   always_comb begin
      state_in    = state_ff;
      step_in     = step_ff;
      is_cal_in   = is_cal_ff;
      cal_done_in = cal_done_ff;
      sample_in   = sample_ff;
      req_ready   = 1'b0;
      out_load    = 1'b0;
      lane_ctrl   = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               sample_in   = req_samples;
               is_cal_in   = req_action;
               cal_done_in = req_action && cal_last;
               state_in    = req_action ? ST_OUT : ST_DIFF;
            end
         end
         ST_DIFF: begin
            lane_ctrl.load_diff = 1'b1;
            state_in = ST_NUM;
         end
         ST_NUM: begin
            lane_ctrl.load_num = 1'b1;
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            lane_ctrl.step = 1'b1;
            step_in = step_ff + STEP_BITS'(1);
            if (step_ff == STEP_BITS'(DIV_STEPS - 1)) begin
               state_in = ST_CLASS;
            end
         end
         ST_CLASS: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold the margin; write on the config strobe
   assign margin_in    = csr_write_enable ? csr_write_data : margin_ff;
   assign rsp_valid_in = out_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         margin_ff    <= MARGIN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         margin_ff    <= margin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and working registers
   always_ff @(posedge clock) begin
      step_ff     <= step_in;
      is_cal_ff   <= is_cal_in;
      cal_done_ff <= cal_done_in;
      sample_ff   <= sample_in;
      dir_ff      <= dir_in;
      if (out_load) begin
         for (int i = 0; i < NUM_LANES; i++) begin
            pct_ff[i] <= is_cal_ff ? PCT_BITS'(0) : lane_pct[i];
         end
         rsp_dir_ff  <= is_cal_ff ? DIR_NEUTRAL : dir_ff;
         rsp_done_ff <= is_cal_ff && cal_done_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_stick1_x_percent = pct_ff[0];
   assign rsp_stick1_y_percent = pct_ff[1];
   assign rsp_stick2_x_percent = pct_ff[2];
   assign rsp_stick2_y_percent = pct_ff[3];
   assign rsp_direction        = rsp_dir_ff;
   assign rsp_calibration_done = rsp_done_ff;

   // Checks
   `JCCC_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, accept, state_ff != ST_IDLE,
      "accepted transaction did not start work")
   `JCCC_ASSERT_IMP(a_step_range, clock, reset, state_ff == ST_DIV,
      step_ff <= STEP_BITS'(DIV_STEPS - 1), "divider step count out of range")
   `JCCC_ASSERT_IMP(a_cal_done_neutral, clock, reset, rsp_valid && rsp_calibration_done,
      rsp_direction == DIR_NEUTRAL && rsp_stick1_x_percent == PCT_BITS'(0),
      "calibration result carries measurement data")

endmodule
